/* hw/rtl/nun_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nun_pkg;

   localparam int INDEX_W  = 16;
   localparam int VALUE_W  = 63;
   localparam int FACTOR_W = 3;

   // Largest representable value; products saturate here.
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   // Largest operands that can be scaled without saturating.
   localparam logic [VALUE_W-1:0] LIMIT_TWO   = VALUE_MAX / 2;
   localparam logic [VALUE_W-1:0] LIMIT_THREE = VALUE_MAX / 3;
   localparam logic [VALUE_W-1:0] LIMIT_FIVE  = VALUE_MAX / 5;

   // One-hot choice of factor, one bit per pointer.
   typedef logic [FACTOR_W-1:0] factor_sel_type;

   localparam factor_sel_type FACTOR_NONE  = 3'b000;
   localparam factor_sel_type FACTOR_TWO   = 3'b001;
   localparam factor_sel_type FACTOR_THREE = 3'b010;
   localparam factor_sel_type FACTOR_FIVE  = 3'b100;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               error;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/nun_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface nun_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/nun_scaler.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shared scaling unit: multiplies a table word by 2, 3 or 5 with one adder
// and saturates at the largest representable value.
module nun_scaler (
   input  wire logic [nun_pkg::VALUE_W-1:0] operand,
   input  wire nun_pkg::factor_sel_type     factor_sel,
   output logic      [nun_pkg::VALUE_W-1:0] product
);

   logic [nun_pkg::VALUE_W-1:0] addend_a;
   logic [nun_pkg::VALUE_W-1:0] addend_b;
   logic [nun_pkg::VALUE_W-1:0] limit;
   logic [nun_pkg::VALUE_W-1:0] sum;

   always_comb begin
      case (factor_sel)
         nun_pkg::FACTOR_TWO: begin
            addend_a = '0;
            addend_b = operand << 1;
            limit    = nun_pkg::LIMIT_TWO;
         end
         nun_pkg::FACTOR_THREE: begin
            addend_a = operand;
            addend_b = operand << 1;
            limit    = nun_pkg::LIMIT_THREE;
         end
         default: begin
            addend_a = operand;
            addend_b = operand << 2;
            limit    = nun_pkg::LIMIT_FIVE;
         end
      endcase
   end

   assign sum     = addend_a + addend_b;
   assign product = (operand > limit) ? nun_pkg::VALUE_MAX : sum;

endmodule

`default_nettype wire

/* hw/rtl/nth_ugly_number_three_pointer.sv */
// Sequence: an index of zero or above MAX_N, and index 1, go straight to ST_DONE,
// which hands the result word to the output register once it is free; otherwise each table
// entry after the first takes an ST_SELECT step that writes it and moves the pointers, then
// ST_FETCH refills each moved pointer's candidate; the last entry needs only ST_SELECT.
// Throughput: one request at a time; the single read port of the table sets the pace.
// Reset: synchronous, active high; clears control state only, the table is never swept.
`timescale 1ns / 1ps
`default_nettype none

module nth_ugly_number_three_pointer #(
   parameter int MAX_N = 2048
) (
   input  wire logic   clock,
   input  wire logic   reset,
   nun_stream_if.sink   req_chan,
   nun_stream_if.source rsp_chan
);

   // Table address width and a count wide enough to hold MAX_N itself.
   localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int CW = $clog2(MAX_N + 1);
   localparam int VW = nun_pkg::VALUE_W;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SELECT = 3'd1;
   localparam logic [2:0] ST_FETCH  = 3'd2;
   localparam logic [2:0] ST_DONE   = 3'd3;

   // The working table of smooth numbers. It is written before it is read on
   // every request, so it needs no clearing.
   logic [VW-1:0] table_mem [MAX_N];

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;   // next entry to be produced
   logic [CW-1:0] target_ff, target_in; // the requested n
   logic [AW-1:0] ptr_two_ff, ptr_two_in;
   logic [AW-1:0] ptr_three_ff, ptr_three_in;
   logic [AW-1:0] ptr_five_ff, ptr_five_in;

   // Candidates: the entry under each pointer, already scaled by its factor.
   logic [VW-1:0] cand_two_ff, cand_two_in;
   logic [VW-1:0] cand_three_ff, cand_three_in;
   logic [VW-1:0] cand_five_ff, cand_five_in;

   // Pointers that advanced and still need their candidate refilled.
   nun_pkg::factor_sel_type pending_ff, pending_in;
   nun_pkg::factor_sel_type rd_sel_ff, rd_sel_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [VW-1:0]           rd_data_ff;

   // The finished answer, held until the output register is free.
   logic [VW-1:0] res_value_ff, res_value_in;
   logic          res_error_ff, res_error_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_error_ff, rsp_error_in;

   // Table port controls.
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [VW-1:0] mem_wd;
   logic          mem_re;
   logic [AW-1:0] mem_ra;

   logic [VW-1:0]           least;
   nun_pkg::factor_sel_type advance;
   nun_pkg::factor_sel_type issue_sel;
   logic [VW-1:0]           scaled;
   logic                    req_bad;

   nun_scaler u_nun_scaler (
      .operand    (rd_data_ff),
      .factor_sel (rd_sel_ff),
      .product    (scaled)
   );

   // Least of the three candidates, and which pointers it came from. Every
   // pointer that ties moves on, which keeps duplicates out of the table.
   always_comb begin
      least = cand_two_ff;
      if (cand_three_ff < least) begin
         least = cand_three_ff;
      end
      if (cand_five_ff < least) begin
         least = cand_five_ff;
      end
      advance = {cand_five_ff == least, cand_three_ff == least, cand_two_ff == least};
   end

   // Lowest pending pointer is refilled first.
   assign issue_sel = pending_ff & (~pending_ff + nun_pkg::FACTOR_TWO);

   assign req_bad = (req_chan.payload.index == '0)
                 || (req_chan.payload.index > nun_pkg::INDEX_W'(MAX_N));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      target_in     = target_ff;
      ptr_two_in    = ptr_two_ff;
      ptr_three_in  = ptr_three_ff;
      ptr_five_in   = ptr_five_ff;
      cand_two_in   = cand_two_ff;
      cand_three_in = cand_three_ff;
      cand_five_in  = cand_five_ff;
      pending_in    = pending_ff;
      rd_sel_in     = rd_sel_ff;
      rd_valid_in   = 1'b0;
      res_value_in  = res_value_ff;
      res_error_in  = res_error_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_error_in  = rsp_error_ff;
      mem_we        = 1'b0;
      mem_wa        = count_ff[AW-1:0];
      mem_wd        = least;
      mem_re        = 1'b0;
      mem_ra        = ptr_two_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_bad) begin
                  // Bad index: answer at once and leave the table alone.
                  res_value_in = '0;
                  res_error_in = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  // Entry 0 is 1, so the first candidates are the factors.
                  mem_we        = 1'b1;
                  mem_wa        = '0;
                  mem_wd        = VW'(1);
                  target_in     = CW'(req_chan.payload.index);
                  count_in      = CW'(1);
                  ptr_two_in    = '0;
                  ptr_three_in  = '0;
                  ptr_five_in   = '0;
                  cand_two_in   = VW'(2);
                  cand_three_in = VW'(3);
                  cand_five_in  = VW'(5);
                  res_value_in  = VW'(1);
                  res_error_in  = 1'b0;
                  if (req_chan.payload.index == nun_pkg::INDEX_W'(1)) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SELECT;
                  end
               end
            end
         end

         ST_SELECT: begin
            mem_we       = 1'b1;
            res_value_in = least;
            count_in     = count_ff + CW'(1);
            ptr_two_in   = ptr_two_ff + AW'(advance[0]);
            ptr_three_in = ptr_three_ff + AW'(advance[1]);
            ptr_five_in  = ptr_five_ff + AW'(advance[2]);
            pending_in   = advance;
            if (count_ff + CW'(1) == target_ff) begin
               // The entry just written is the answer; no refill needed.
               state_in = ST_DONE;
            end else begin
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            // One table read goes out per cycle while the word read in the
            // cycle before is scaled into its candidate.
            if (pending_ff != nun_pkg::FACTOR_NONE) begin
               mem_re      = 1'b1;
               rd_valid_in = 1'b1;
               rd_sel_in   = issue_sel;
               pending_in  = pending_ff & ~issue_sel;
               case (issue_sel)
                  nun_pkg::FACTOR_TWO:   mem_ra = ptr_two_ff;
                  nun_pkg::FACTOR_THREE: mem_ra = ptr_three_ff;
                  default:               mem_ra = ptr_five_ff;
               endcase
            end
            if (rd_valid_ff) begin
               case (rd_sel_ff)
                  nun_pkg::FACTOR_TWO:   cand_two_in   = scaled;
                  nun_pkg::FACTOR_THREE: cand_three_in = scaled;
                  default:               cand_five_in  = scaled;
               endcase
            end
            if (pending_ff == nun_pkg::FACTOR_NONE) begin
               state_in = ST_SELECT;
            end
         end

         ST_DONE: begin
            // Hand the answer over once the output register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_error_in = res_error_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= table_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= nun_pkg::FACTOR_NONE;
         ptr_two_ff   <= '0;
         ptr_three_ff <= '0;
         ptr_five_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
         ptr_two_ff   <= ptr_two_in;
         ptr_three_ff <= ptr_three_in;
         ptr_five_ff  <= ptr_five_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      target_ff     <= target_in;
      cand_two_ff   <= cand_two_in;
      cand_three_ff <= cand_three_in;
      cand_five_ff  <= cand_five_in;
      rd_sel_ff     <= rd_sel_in;
      res_value_ff  <= res_value_in;
      res_error_ff  <= res_error_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.payload.value = rsp_value_ff;
   assign rsp_chan.payload.error = rsp_error_ff;

endmodule

`default_nettype wire

/* hw/rtl/nun_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module nun_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [nun_pkg::VALUE_W-1:0] rsp_value,
   input wire logic                        rsp_error
);

   // A result word waiting on the sink is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // An error word always carries a zero value.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_value == '0)
      else $error("error word with non-zero value");

   // Every smooth number is at least one.
   a_value_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> rsp_value != '0)
      else $error("good word with zero value");

   // Only one request is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind nth_ugly_number_three_pointer nun_checker u_nun_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.payload.value),
   .rsp_error (rsp_chan.payload.error)
);

`default_nettype wire
